// ===== hdl/sis_pkg.sv =====
// shared types, codes and widths for the sorted id set
package sis_pkg;

  localparam int KEY_W           = 32;
  localparam int IDX_W           = 8;
  localparam int CAP_W           = 9;
  localparam int STAT_W          = 3;
  localparam int TALLY_W         = 32;
  localparam int MAX_ENTRIES_DEF = 256;

  // request kinds
  localparam logic [1:0] MODE_ADD      = 2'd0;
  localparam logic [1:0] MODE_REMOVE   = 2'd1;
  localparam logic [1:0] MODE_CONTAINS = 2'd2;
  localparam logic [1:0] MODE_READ     = 2'd3;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_ZERO_ID   = 3'd1;
  localparam logic [STAT_W-1:0] ST_NO_STORE  = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd3;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd4;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd5;

  // cell update operations
  localparam logic [1:0] OP_HOLD = 2'd0;
  localparam logic [1:0] OP_INS  = 2'd1;
  localparam logic [1:0] OP_REM  = 2'd2;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    logic       cmp;
    logic [1:0] op;
  } sis_ctl_t;

endpackage

// ===== hdl/sis_cell.sv =====
// one storage cell of the sorted chain: compare, shift and read select
module sis_cell import sis_pkg::*; #(
  parameter int CELL_IDX = 0,
  parameter int CNT_W    = 9
) (
  input  logic             clk,
  input  sis_ctl_t         ctl,
  input  logic [KEY_W-1:0] cmp_key,
  input  logic [IDX_W-1:0] cmp_index,
  input  logic [KEY_W-1:0] ins_key,
  input  logic [CNT_W-1:0] fill_count,
  input  logic             left_lt,
  input  logic [KEY_W-1:0] left_entry,
  input  logic [KEY_W-1:0] right_entry,
  output logic             lt,
  output logic             eq,
  output logic [KEY_W-1:0] rd_val,
  output logic [KEY_W-1:0] entry
);

  logic [KEY_W-1:0] entry_r;
  logic [KEY_W-1:0] entry_nxt;
  logic             lt_r;
  logic             eq_r;
  logic [KEY_W-1:0] rd_r;
  logic             occ;

  assign occ = (CELL_IDX < int'(fill_count));

  // compare phase, taken when a request is transferred in
  always_ff @(posedge clk) begin
    if (ctl.cmp) begin
      lt_r <= occ && (entry_r < cmp_key);
      eq_r <= occ && (entry_r == cmp_key);
      rd_r <= (occ && (CELL_IDX == int'(cmp_index))) ? entry_r : '0;
    end
  end

  // update phase: insert opens a gap to the right, remove closes it from the right
  always_comb begin
    entry_nxt = entry_r;
    case (ctl.op)
      OP_INS: begin
        if (!lt_r) begin
          entry_nxt = left_lt ? ins_key : left_entry;
        end
      end
      OP_REM: begin
        if (!lt_r) begin
          entry_nxt = right_entry;
        end
      end
      default: entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign lt     = lt_r;
  assign eq     = eq_r;
  assign rd_val = rd_r;
  assign entry  = entry_r;

endmodule

// ===== hdl/sorted_id_set.sv =====
// Sorted set of nonzero 32-bit ids held in a chain of compare/shift cells.
// out_valid is registered: the compare is taken at the input transfer, the update when the compare state finishes.
// No new request is taken until the current one finishes, since in_ready is low in the compare state;
// a result still waiting on out_ready holds back the update and the next request.
// Reset: synchronous active-low rst_n empties the set, clears the refusal tally
// and sets the capacity to zero; cell contents are not cleared.
module sorted_id_set import sis_pkg::*; #(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  // configuration write
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CAP_W-1:0]   cfg_capacity_in_use,
  // request channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_mode,
  input  logic [KEY_W-1:0]   in_member_key,
  input  logic [IDX_W-1:0]   in_entry_index,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [STAT_W-1:0]  out_status,
  output logic               out_present,
  output logic [KEY_W-1:0]   out_entry_value,
  output logic [CAP_W-1:0]   out_member_total,
  output logic [TALLY_W-1:0] out_refusal_tally
);

  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_CMP  = 1'b1;

  logic               state_r, state_nxt;
  logic [CAP_W-1:0]   cap_r;
  logic [CNT_W-1:0]   fill_r, fill_nxt;
  logic [TALLY_W-1:0] tally_r, tally_nxt;
  logic [1:0]         mode_r;
  logic [KEY_W-1:0]   key_r;

  logic               out_valid_r;
  logic [STAT_W-1:0]  status_r, status_nxt;
  logic               present_r, present_nxt;
  logic [KEY_W-1:0]   value_r, value_nxt;
  logic [CAP_W-1:0]   total_r;
  logic [TALLY_W-1:0] tally_res_r;

  logic               in_fire, cfg_fire, fin;
  logic               hit;
  logic [KEY_W-1:0]   rd_any;
  logic [CMP_W-1:0]   cap_ext, max_ext, fill_ext, cap_use;
  logic               cap_zero, full, key_zero, do_ins, do_rem, refuse;
  sis_ctl_t           ctl;

  logic               lt_w  [MAX_ENTRIES];
  logic               eq_w  [MAX_ENTRIES];
  logic [KEY_W-1:0]   rd_w  [MAX_ENTRIES];
  logic [KEY_W-1:0]   ent_w [MAX_ENTRIES];

  // handshakes; a pending configuration write goes ahead of a request
  assign cfg_ready = (state_r == S_IDLE);
  assign in_ready  = (state_r == S_IDLE) && !cfg_valid;
  assign in_fire   = in_valid && in_ready;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign fin       = (state_r == S_CMP) && (!out_valid_r || out_ready);

  // chain of cells
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic             left_lt;
    logic [KEY_W-1:0] left_entry;
    logic [KEY_W-1:0] right_entry;

    if (i == 0) begin : g_head
      assign left_lt    = 1'b1;
      assign left_entry = key_r;
    end else begin : g_body
      assign left_lt    = lt_w[i-1];
      assign left_entry = ent_w[i-1];
    end

    if (i == MAX_ENTRIES - 1) begin : g_tail
      assign right_entry = ent_w[i];
    end else begin : g_mid
      assign right_entry = ent_w[i+1];
    end

    sis_cell #(
      .CELL_IDX (i),
      .CNT_W    (CNT_W)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .cmp_key     (in_member_key),
      .cmp_index   (in_entry_index),
      .ins_key     (key_r),
      .fill_count  (fill_r),
      .left_lt     (left_lt),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .lt          (lt_w[i]),
      .eq          (eq_w[i]),
      .rd_val      (rd_w[i]),
      .entry       (ent_w[i])
    );
  end

  // match and read reduction over the cells
  always_comb begin
    hit    = 1'b0;
    rd_any = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      hit    = hit | eq_w[i];
      rd_any = rd_any | rd_w[i];
    end
  end

  // usable capacity and request decode
  assign cap_ext  = CMP_W'(cap_r);
  assign max_ext  = CMP_W'(MAX_ENTRIES);
  assign fill_ext = CMP_W'(fill_r);
  assign cap_use  = (cap_ext > max_ext) ? max_ext : cap_ext;
  assign cap_zero = (cap_r == '0);
  assign full     = (fill_ext >= cap_use);
  assign key_zero = (key_r == '0);

  assign do_ins = (mode_r == MODE_ADD) && !key_zero && !cap_zero && !hit && !full;
  assign do_rem = (mode_r == MODE_REMOVE) && !key_zero && !cap_zero &&
                  (fill_r != '0) && hit;
  assign refuse = (mode_r == MODE_ADD) && !key_zero && (cap_zero || (!hit && full));

  always_comb begin
    ctl.cmp = in_fire;
    ctl.op  = OP_HOLD;
    if (fin && do_ins) begin
      ctl.op = OP_INS;
    end else if (fin && do_rem) begin
      ctl.op = OP_REM;
    end
  end

  // result fields
  always_comb begin
    status_nxt  = ST_OK;
    present_nxt = 1'b0;
    value_nxt   = '0;
    case (mode_r)
      MODE_ADD: begin
        if (key_zero) begin
          status_nxt = ST_ZERO_ID;
        end else if (cap_zero) begin
          status_nxt = ST_NO_STORE;
        end else if (!hit && full) begin
          status_nxt = ST_FULL;
        end
      end
      MODE_REMOVE: begin
        if (key_zero) begin
          status_nxt = ST_ZERO_ID;
        end else if (cap_zero) begin
          status_nxt = ST_NO_STORE;
        end else if (fill_r == '0) begin
          status_nxt = ST_EMPTY;
        end else if (!hit) begin
          status_nxt = ST_NOT_FOUND;
        end
      end
      MODE_CONTAINS: begin
        if (key_zero) begin
          status_nxt = ST_ZERO_ID;
        end else begin
          present_nxt = hit;
        end
      end
      default: value_nxt = rd_any;
    endcase
  end

  // fill count and tally
  always_comb begin
    fill_nxt  = fill_r;
    tally_nxt = tally_r;
    if (fin && do_ins) begin
      fill_nxt = fill_r + 1'b1;
    end else if (fin && do_rem) begin
      fill_nxt = fill_r - 1'b1;
    end
    if (fin && refuse) begin
      tally_nxt = tally_r + 1'b1;
    end
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_fire) state_nxt = S_CMP;
      S_CMP:   if (fin) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cap_r       <= '0;
      fill_r      <= '0;
      tally_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_fire) begin
        cap_r   <= cfg_capacity_in_use;
        fill_r  <= '0;
        tally_r <= '0;
      end else begin
        fill_r  <= fill_nxt;
        tally_r <= tally_nxt;
      end
      if (fin) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request capture and result payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      mode_r <= in_mode;
      key_r  <= in_member_key;
    end
    if (fin) begin
      status_r    <= status_nxt;
      present_r   <= present_nxt;
      value_r     <= value_nxt;
      total_r     <= CAP_W'(fill_nxt);
      tally_res_r <= tally_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_present       = present_r;
  assign out_entry_value   = value_r;
  assign out_member_total  = total_r;
  assign out_refusal_tally = tally_res_r;

`ifndef SYNTH
  // fill count never passes the usable capacity
  a_fill_in_cap: assert property (@(posedge clk) disable iff (!rst_n)
    fill_ext <= cap_use)
    else $error("fill count above usable capacity");

  // an insert grows the set by exactly one
  a_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (fin && do_ins) |=> (fill_r == $past(fill_r) + 1'b1))
    else $error("insert did not grow the set by one");

  // a capacity write empties the set and clears the tally
  a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_fire |=> (fill_r == '0) && (tally_r == '0))
    else $error("capacity write did not empty the set");
`endif

endmodule

// ===== sim/sorted_id_set_test.sv =====
// self-checking testbench for the sorted id set: directed corner cases, then random traffic
module sorted_id_set_test import sis_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_LIMIT = 2000;
  localparam int REPORT_MAX  = 50;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic               present;
    logic [KEY_W-1:0]   value;
    logic [CAP_W-1:0]   total;
    logic [TALLY_W-1:0] tally;
  } set_result_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CAP_W-1:0]   cfg_capacity_in_use;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_mode;
  logic [KEY_W-1:0]   in_member_key;
  logic [IDX_W-1:0]   in_entry_index;
  logic               out_valid;
  logic               out_ready;
  logic [STAT_W-1:0]  out_status;
  logic               out_present;
  logic [KEY_W-1:0]   out_entry_value;
  logic [CAP_W-1:0]   out_member_total;
  logic [TALLY_W-1:0] out_refusal_tally;

  // mirror of the set contents and counters
  logic [KEY_W-1:0]   members [MAX_ENTRIES_DEF];
  int                 fill_total;
  logic [CAP_W-1:0]   cap_reg;
  logic [TALLY_W-1:0] refusals;

  set_result_t        pending_results[$];
  logic [KEY_W-1:0]   seen_keys[$];
  int                 mismatches;
  int                 send_idle_pct;
  int                 recv_stall_pct;
  int                 mode_count [4];
  int                 full_refusals;
  int                 peak_fill;

  sorted_id_set dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_capacity_in_use (cfg_capacity_in_use),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_mode             (in_mode),
    .in_member_key       (in_member_key),
    .in_entry_index      (in_entry_index),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_present         (out_present),
    .out_entry_value     (out_entry_value),
    .out_member_total    (out_member_total),
    .out_refusal_tally   (out_refusal_tally)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // first position not below key, with hit when it matches
  function automatic int locate(input logic [KEY_W-1:0] key, output bit hit);
    int pos;
    pos = 0;
    while (pos < fill_total && members[pos] < key) pos++;
    hit = (pos < fill_total) && (members[pos] == key);
    return pos;
  endfunction

  // expected result of one request, updating the mirrored set
  function automatic set_result_t predict_set_op(input logic [1:0] mode,
                                                 input logic [KEY_W-1:0] key,
                                                 input logic [IDX_W-1:0] idx);
    set_result_t res;
    int room;
    int slot;
    bit hit;
    res = '0;
    res.status = ST_OK;
    room = (int'(cap_reg) > MAX_ENTRIES_DEF) ? MAX_ENTRIES_DEF : int'(cap_reg);
    slot = locate(key, hit);
    case (mode)
      MODE_ADD: begin
        if (key == '0) begin
          res.status = ST_ZERO_ID;
        end else if (room == 0) begin
          res.status = ST_NO_STORE;
          refusals++;
        end else if (!hit) begin
          if (fill_total >= room) begin
            res.status = ST_FULL;
            refusals++;
          end else begin
            // open a gap at the sorted position
            for (int i = fill_total; i > slot; i--) members[i] = members[i-1];
            members[slot] = key;
            fill_total++;
          end
        end
      end
      MODE_REMOVE: begin
        if (key == '0) begin
          res.status = ST_ZERO_ID;
        end else if (room == 0) begin
          res.status = ST_NO_STORE;
        end else if (fill_total == 0) begin
          res.status = ST_EMPTY;
        end else if (!hit) begin
          res.status = ST_NOT_FOUND;
        end else begin
          // close the gap
          for (int i = slot; i < fill_total - 1; i++) members[i] = members[i+1];
          fill_total--;
        end
      end
      MODE_CONTAINS: begin
        if (key == '0) res.status = ST_ZERO_ID;
        else res.present = hit;
      end
      default: begin
        if (int'(idx) < fill_total) res.value = members[idx];
      end
    endcase
    res.total = fill_total[CAP_W-1:0];
    res.tally = refusals;
    return res;
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
    end
  endfunction

  // monitor: check results, track configuration and requests
  always @(posedge clk) begin
    set_result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          $error("result transfer with no request outstanding");
        end else begin
          want = pending_results.pop_front();
          compare_field("status", 32'(want.status), 32'(out_status));
          compare_field("present", 32'(want.present), 32'(out_present));
          compare_field("entry_value", want.value, out_entry_value);
          compare_field("member_total", 32'(want.total), 32'(out_member_total));
          compare_field("refusal_tally", want.tally, out_refusal_tally);
        end
      end
      if (cfg_valid && cfg_ready) begin
        cap_reg    = cfg_capacity_in_use;
        fill_total = 0;
        refusals   = '0;
      end
      if (in_valid && in_ready) begin
        want = predict_set_op(in_mode, in_member_key, in_entry_index);
        pending_results.push_back(want);
        mode_count[in_mode]++;
        if (want.status == ST_FULL) full_refusals++;
        if (fill_total > peak_fill) peak_fill = fill_total;
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog on cycles without any transfer
  initial begin : watchdog
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
          (cfg_valid && cfg_ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("sorted_id_set_test failed");
    $finish;
  end

  // one request transfer, with random idle cycles in front
  task automatic send_request(input logic [1:0] mode, input logic [KEY_W-1:0] key,
                              input logic [IDX_W-1:0] idx);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_mode        <= mode;
    in_member_key  <= key;
    in_entry_index <= idx;
    do @(posedge clk); while (!in_ready);
  endtask

  // drop valid and wait for every outstanding result
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    settle();
    @(negedge clk);
    cfg_valid           <= 1'b1;
    cfg_capacity_in_use <= cap;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    seen_keys.delete();
  endtask

  // key mix: zero, all ones, fresh values, or ids already used
  function automatic logic [KEY_W-1:0] pick_key(input int fresh_pct, input int key_span);
    int roll;
    roll = $urandom_range(99);
    if (roll < 3) return '0;
    if (roll < 6) return '1;
    if (seen_keys.size() == 0 || $urandom_range(99) < fresh_pct) begin
      if (key_span != 0) return KEY_W'($urandom_range(key_span, 1));
      return $urandom;
    end
    return seen_keys[$urandom_range(seen_keys.size() - 1)];
  endfunction

  task automatic run_batch(input int count, input int w_add, input int w_rem, input int w_has,
                           input int key_span, input int add_fresh);
    int roll;
    logic [1:0] mode;
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] idx;
    repeat (count) begin
      roll = $urandom_range(99);
      if (roll < w_add) mode = MODE_ADD;
      else if (roll < w_add + w_rem) mode = MODE_REMOVE;
      else if (roll < w_add + w_rem + w_has) mode = MODE_CONTAINS;
      else mode = MODE_READ;
      key = pick_key((mode == MODE_ADD) ? add_fresh : 25, key_span);
      if (mode == MODE_ADD && key != '0) begin
        seen_keys.push_back(key);
        if (seen_keys.size() > 512) void'(seen_keys.pop_front());
      end
      idx = $urandom_range(1) ? IDX_W'($urandom_range(255)) : IDX_W'($urandom_range(15));
      send_request(mode, key, idx);
    end
  endtask

  // reset capacity of zero: every request kind and zero id
  task automatic test_empty_storage();
    send_request(MODE_ADD, 32'd5, '0);
    send_request(MODE_REMOVE, 32'd5, '0);
    send_request(MODE_CONTAINS, 32'd5, '0);
    send_request(MODE_CONTAINS, '0, '0);
    send_request(MODE_ADD, '0, '0);
    send_request(MODE_REMOVE, '0, '0);
    send_request(MODE_READ, '0, '0);
  endtask

  // two-entry set: empty, duplicate, full, not found, extreme ids and indexes
  task automatic test_two_entry_set();
    write_capacity(CAP_W'(2));
    send_request(MODE_REMOVE, 32'd7, '0);
    send_request(MODE_ADD, '1, '0);
    send_request(MODE_ADD, 32'd1, '0);
    send_request(MODE_ADD, 32'd1, '0);
    send_request(MODE_ADD, 32'd3, '1);
    send_request(MODE_CONTAINS, '1, '0);
    send_request(MODE_CONTAINS, 32'd2, '0);
    send_request(MODE_READ, '0, '0);
    send_request(MODE_READ, '0, IDX_W'(1));
    send_request(MODE_READ, '1, '1);
    send_request(MODE_REMOVE, 32'd2, '0);
    send_request(MODE_REMOVE, 32'd1, '0);
    send_request(MODE_READ, '0, '0);
  endtask

  // small random capacities with a narrow key range for many hits
  task automatic test_small_sets();
    repeat (4) begin
      write_capacity(CAP_W'($urandom_range(12, 2)));
      run_batch(30, 40, 30, 15, 20, 50);
    end
  endtask

  // grow to the limit with mostly fresh ids, then churn a full set
  task automatic test_fill_to_capacity(input logic [CAP_W-1:0] cap);
    write_capacity(cap);
    run_batch(360, 88, 3, 4, 0, 90);
    run_batch(60, 30, 40, 15, 0, 50);
  endtask

  task automatic test_single_entry();
    write_capacity(CAP_W'(1));
    run_batch(30, 40, 30, 15, 4, 50);
  endtask

  task automatic test_zero_capacity();
    write_capacity('0);
    run_batch(15, 50, 20, 15, 8, 50);
  endtask

  // main sequence
  initial begin
    rst_n               = 1'b0;
    cfg_valid           = 1'b0;
    cfg_capacity_in_use = '0;
    in_valid            = 1'b0;
    in_mode             = MODE_ADD;
    in_member_key       = '0;
    in_entry_index      = '0;
    out_ready           = 1'b0;
    fill_total          = 0;
    cap_reg             = '0;
    refusals            = '0;
    mismatches          = 0;
    full_refusals       = 0;
    peak_fill           = 0;
    mode_count          = '{default: 0};
    send_idle_pct       = 33;
    recv_stall_pct      = 66;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_storage();
    test_two_entry_set();

    // idling: sender light then heavy, then none on either side
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct  = (phase == 0) ? 33 : (phase == 1) ? 66 : 0;
      recv_stall_pct = (phase == 0) ? 66 : (phase == 1) ? 33 : 0;
      test_small_sets();
      if (phase == 0) test_fill_to_capacity(CAP_W'(MAX_ENTRIES_DEF));
      else if (phase == 1) test_fill_to_capacity('1);
      else test_fill_to_capacity(CAP_W'($urandom_range(510, 257)));
      test_single_entry();
      test_zero_capacity();
    end

    settle();
    repeat (4) @(posedge clk);

    $display("covered %0d adds, %0d removes, %0d queries, %0d indexed reads",
             mode_count[MODE_ADD], mode_count[MODE_REMOVE], mode_count[MODE_CONTAINS],
             mode_count[MODE_READ]);
    $display("peak occupancy %0d, %0d adds refused on a full set, %0d mismatches",
             peak_fill, full_refusals, mismatches);
    if (mismatches == 0)
      $display("sorted_id_set_test passed");
    else
      $display("sorted_id_set_test failed");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/sis_pkg.sv
hdl/sis_cell.sv
hdl/sorted_id_set.sv
sim/sorted_id_set_test.sv
